/* src/ate_pkg.sv */
// ----------------------------------------------------------------------------
// ate_pkg
// Types, constants and register codes for the exponential target calculator.
// ----------------------------------------------------------------------------
package ate_pkg;

   localparam int WORD_W     = 64;
   localparam int TGT_W      = 256;
   localparam int PROD_W     = 288;
   localparam int DEV_W      = 50;
   localparam int DIV_BITS   = 64;
   localparam int DIVR_W     = 32;
   localparam int SHIFT_W    = 10;
   localparam int LANE_W     = 49;
   localparam int LANES      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // quotient bits resolved per divider stage
   localparam int DIV_STEPS_DEF = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_LIFE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT1    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT3    = 3'd4;

   localparam logic [31:0]     HALF_LIFE_RST = 32'd172800;
   localparam logic [63:0]     LIMIT_LO_RST  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]     LIMIT_HI_RST  = 64'h0000_0000_FFFF_FFFF;

   localparam logic [47:0]     POLY_A   = 48'd195766423245049;
   localparam logic [29:0]     POLY_B   = 30'd971821376;
   localparam logic [12:0]     POLY_C   = 13'd5127;
   localparam logic [63:0]     POLY_RND = 64'h0000_8000_0000_0000;

   localparam logic [DEV_W-1:0]   DEV_BOUND = 50'h0_8000_0000_0000;
   localparam logic [47:0]        K_BIAS    = 48'd272;
   localparam logic [SHIFT_W-1:0] K_MAX     = 10'd544;

   typedef struct packed {
      logic [63:0]        ref_word0;
      logic [63:0]        ref_word1;
      logic [63:0]        ref_word2;
      logic [63:0]        ref_word3;
      logic [15:0]        spacing;
      logic signed [47:0] time_delta;
      logic [31:0]        height_delta;
   } req_type;

   typedef struct packed {
      logic [63:0] next_word0;
      logic [63:0] next_word1;
      logic [63:0] next_word2;
      logic [63:0] next_word3;
      logic        input_error;
   } rsp_type;

   // data that rides along the divider pipeline
   typedef struct packed {
      logic [TGT_W-1:0] ref_val;
      logic             neg;
      logic             err;
   } div_side_type;

endpackage

/* src/asert_target_exponential.sv */
// ----------------------------------------------------------------------------
// asert_target_exponential
// Exponential target calculator: deviation, 48.16 exponent, cubic factor,
// wide product and shift with clamping to the configured limit.
// ----------------------------------------------------------------------------
//   channel  | ports                        | word
//   request  | req_valid/req_ready/req_data | reference, spacing, time, height
//   response | rsp_valid/rsp_ready/rsp_data | next target, input error
//   csr      | csr_wr_en/csr_index/csr_wdata | half-life, limit words
//
// one word per cycle while the response is not stalled; the pipe runs through
// the pipelined divider stages plus the factor, product and shift stages
// the whole pipe advances when the response register is empty or taken
// reset is synchronous; it empties the pipe and restores the registers
// ----------------------------------------------------------------------------
module asert_target_exponential #(
   parameter int DIV_STEPS = ate_pkg::DIV_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ate_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ate_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [ate_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ate_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ate_pkg::*;

   logic              adv;
   logic [31:0]       half_life_ff;
   logic [63:0]       limit_ff [4];
   logic [TGT_W-1:0]  lim;

   // valid bits of the stages outside the divider
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, v11_ff, v12_ff, rsp_valid_ff;

   assign lim       = {limit_ff[3], limit_ff[2], limit_ff[1], limit_ff[0]};
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_life_ff <= HALF_LIFE_RST;
         limit_ff[0]  <= LIMIT_LO_RST;
         limit_ff[1]  <= LIMIT_LO_RST;
         limit_ff[2]  <= LIMIT_LO_RST;
         limit_ff[3]  <= LIMIT_HI_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HALF_LIFE: half_life_ff <= csr_wdata[31:0];
            CSR_LIMIT0:    limit_ff[0]  <= csr_wdata;
            CSR_LIMIT1:    limit_ff[1]  <= csr_wdata;
            CSR_LIMIT2:    limit_ff[2]  <= csr_wdata;
            CSR_LIMIT3:    limit_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: deviation and reference check
   logic [TGT_W-1:0] ref_in;
   logic [47:0]      sched_in;
   logic [DEV_W-1:0] dev_in;
   logic             eref_in;
   logic [TGT_W-1:0] ref1_ff;
   logic [DEV_W-1:0] dev1_ff;
   logic             err1_ff;

   assign ref_in   = {req_data.ref_word3, req_data.ref_word2,
                      req_data.ref_word1, req_data.ref_word0};
   assign sched_in = req_data.spacing * req_data.height_delta;
   assign dev_in   = {{2{req_data.time_delta[47]}}, req_data.time_delta} - {2'b00, sched_in};
   assign eref_in  = (ref_in == '0) || (ref_in > lim);

   always_ff @(posedge clock) begin
      if (adv) begin
         ref1_ff <= ref_in;
         dev1_ff <= dev_in;
         err1_ff <= eref_in;
      end
   end

   // stage 2: magnitude, saturation and divisor
   logic               neg2_in;
   logic [DEV_W-1:0]   mag_in;
   logic               sat_in;
   logic [46:0]        mag47_in;
   logic               hlz_in;
   logic [DIV_BITS-1:0] num2_ff;
   logic [DIVR_W-1:0]  dvs2_ff;
   div_side_type       side2_ff;

   assign neg2_in  = dev1_ff[DEV_W-1];
   assign mag_in   = neg2_in ? (~dev1_ff + 50'd1) : dev1_ff;
   assign sat_in   = mag_in >= DEV_BOUND;
   assign mag47_in = sat_in ? {47{1'b1}} : mag_in[46:0];
   assign hlz_in   = half_life_ff == '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         num2_ff          <= {1'b0, mag47_in, 16'h0000};
         dvs2_ff          <= hlz_in ? 32'd1 : half_life_ff;
         side2_ff.ref_val <= ref1_ff;
         side2_ff.neg     <= neg2_in;
         side2_ff.err     <= err1_ff | sat_in | hlz_in;
      end
   end

   logic                dq_vld;
   logic [DIV_BITS-1:0] dq_quo;
   div_side_type        dq_side;

   ate_divider #(.STEPS(DIV_STEPS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (v2_ff),
      .in_num   (num2_ff),
      .in_dvs   (dvs2_ff),
      .in_side  (side2_ff),
      .out_vld  (dq_vld),
      .out_quo  (dq_quo),
      .out_side (dq_side)
   );

   // stage 3: split exponent into shift amount and fraction
   // k is the right shift of {product, 256 zeros} that lands the result
   logic [47:0]        spos_in;
   logic [63:0]        qround_in;
   logic [47:0]        sneg_in;
   logic [47:0]        kpos_in;
   logic [47:0]        kneg_in;
   logic [SHIFT_W-1:0] k3_in;
   logic [15:0]        f3_in;
   logic [SHIFT_W-1:0] k3_ff;
   logic [15:0]        f3_ff;
   logic [TGT_W-1:0]   ref3_ff;
   logic               err3_ff;

   assign spos_in   = dq_quo[63:16];
   assign qround_in = dq_quo + 64'd65535;
   assign sneg_in   = qround_in[63:16];
   assign kpos_in   = K_BIAS - spos_in;
   assign kneg_in   = K_BIAS + sneg_in;

   always_comb begin
      if (!dq_side.neg) begin
         k3_in = (spos_in >= K_BIAS) ? '0 : kpos_in[SHIFT_W-1:0];
         f3_in = dq_quo[15:0];
      end else begin
         k3_in = (sneg_in >= K_BIAS) ? K_MAX : kneg_in[SHIFT_W-1:0];
         f3_in = ~dq_quo[15:0] + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k3_ff   <= k3_in;
         f3_ff   <= f3_in;
         ref3_ff <= dq_side.ref_val;
         err3_ff <= dq_side.err;
      end
   end

   // stages 4 to 7: cubic factor
   logic [63:0]        af4_ff;
   logic [31:0]        fsq4_ff;
   logic [15:0]        f4_ff;
   logic [SHIFT_W-1:0] k4_ff;
   logic [TGT_W-1:0]   ref4_ff;
   logic               err4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         af4_ff  <= {16'h0000, POLY_A} * {48'h0, f3_ff};
         fsq4_ff <= f3_ff * f3_ff;
         f4_ff   <= f3_ff;
         k4_ff   <= k3_ff;
         ref4_ff <= ref3_ff;
         err4_ff <= err3_ff;
      end
   end

   logic [63:0]        af5_ff;
   logic [63:0]        bf5_ff;
   logic [47:0]        fcb5_ff;
   logic [SHIFT_W-1:0] k5_ff;
   logic [TGT_W-1:0]   ref5_ff;
   logic               err5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         af5_ff  <= af4_ff;
         bf5_ff  <= {34'h0, POLY_B} * {32'h0, fsq4_ff};
         fcb5_ff <= {16'h0000, fsq4_ff} * {32'h0, f4_ff};
         k5_ff   <= k4_ff;
         ref5_ff <= ref4_ff;
         err5_ff <= err4_ff;
      end
   end

   logic [63:0]        cf6_ff;
   logic [63:0]        part6_ff;
   logic [SHIFT_W-1:0] k6_ff;
   logic [TGT_W-1:0]   ref6_ff;
   logic               err6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cf6_ff   <= {51'h0, POLY_C} * {16'h0000, fcb5_ff};
         part6_ff <= af5_ff + bf5_ff + POLY_RND;
         k6_ff    <= k5_ff;
         ref6_ff  <= ref5_ff;
         err6_ff  <= err5_ff;
      end
   end

   logic [63:0]        poly_in;
   logic [16:0]        fac7_ff;
   logic [SHIFT_W-1:0] k7_ff;
   logic [TGT_W-1:0]   ref7_ff;
   logic               err7_ff;

   assign poly_in = part6_ff + cf6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fac7_ff <= {1'b1, poly_in[63:48]};
         k7_ff   <= k6_ff;
         ref7_ff <= ref6_ff;
         err7_ff <= err6_ff;
      end
   end

   // stage 8: per-limb partial products
   logic [LANE_W-1:0]  lane8_ff [LANES];
   logic [SHIFT_W-1:0] k8_ff;
   logic               err8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            lane8_ff[i] <= {17'h0, ref7_ff[32*i +: 32]} * {32'h0, fac7_ff};
         end
         k8_ff   <= k7_ff;
         err8_ff <= err7_ff;
      end
   end

   // stage 9: even and odd limbs do not overlap, one add joins them
   logic [PROD_W-1:0]  even_in;
   logic [PROD_W-1:0]  odd_in;
   logic [PROD_W-1:0]  prod9_ff;
   logic [SHIFT_W-1:0] k9_ff;
   logic               err9_ff;

   always_comb begin
      even_in = '0;
      odd_in  = '0;
      for (int i = 0; i < LANES; i++) begin
         if (i % 2 == 0) begin
            even_in[32*i +: LANE_W] = lane8_ff[i];
         end else begin
            odd_in[32*i +: LANE_W] = lane8_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod9_ff <= even_in + odd_in;
         k9_ff    <= k8_ff;
         err9_ff  <= err8_ff;
      end
   end

   // stage 10: overflow test and word-granular shift
   logic [PROD_W-1:0]        himask_in;
   logic [PROD_W+TGT_W-1:0]  wide_in;
   logic [PROD_W+TGT_W-1:0]  coarse_in;
   logic [TGT_W+30:0]        coarse10_ff;
   logic [4:0]               k10_ff;
   logic                     clamp10_ff;
   logic                     err10_ff;

   always_comb begin
      for (int i = 0; i < PROD_W; i++) begin
         himask_in[i] = SHIFT_W'(i) >= k9_ff;
      end
   end

   assign wide_in   = {prod9_ff, {TGT_W{1'b0}}};
   assign coarse_in = wide_in >> {k9_ff[SHIFT_W-1:5], 5'b00000};

   always_ff @(posedge clock) begin
      if (adv) begin
         coarse10_ff <= coarse_in[TGT_W+30:0];
         k10_ff      <= k9_ff[4:0];
         clamp10_ff  <= |(prod9_ff & himask_in);
         err10_ff    <= err9_ff;
      end
   end

   // stage 11: bit-granular shift
   logic [TGT_W+30:0] fine_in;
   logic [TGT_W-1:0]  raw11_ff;
   logic              clamp11_ff;
   logic              err11_ff;

   assign fine_in = coarse10_ff >> k10_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         raw11_ff   <= fine_in[TGT_W-1:0];
         clamp11_ff <= clamp10_ff;
         err11_ff   <= err10_ff;
      end
   end

   // stage 12: compare against the limit
   logic [TGT_W-1:0] raw12_ff;
   logic             clamp12_ff;
   logic             zero12_ff;
   logic             gt12_ff;
   logic             limz12_ff;
   logic             err12_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         raw12_ff   <= raw11_ff;
         clamp12_ff <= clamp11_ff;
         zero12_ff  <= raw11_ff == '0;
         gt12_ff    <= raw11_ff > lim;
         limz12_ff  <= lim == '0;
         err12_ff   <= err11_ff;
      end
   end

   // response register
   logic [TGT_W-1:0] res_in;
   rsp_type          rsp_data_ff;

   always_comb begin
      if (clamp12_ff) begin
         res_in = limz12_ff ? TGT_W'(1) : lim;
      end else if (zero12_ff) begin
         res_in = TGT_W'(1);
      end else if (gt12_ff) begin
         res_in = lim;
      end else begin
         res_in = raw12_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.next_word0  <= res_in[63:0];
         rsp_data_ff.next_word1  <= res_in[127:64];
         rsp_data_ff.next_word2  <= res_in[191:128];
         rsp_data_ff.next_word3  <= res_in[255:192];
         rsp_data_ff.input_error <= err12_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= dq_vld;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         v11_ff       <= v10_ff;
         v12_ff       <= v11_ff;
         rsp_valid_ff <= v12_ff;
      end
   end

endmodule

/* src/ate_divider.sv */
// ----------------------------------------------------------------------------
// ate_divider
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module ate_divider #(
   parameter int STEPS = ate_pkg::DIV_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [ate_pkg::DIV_BITS-1:0] in_num,
   input  logic [ate_pkg::DIVR_W-1:0] in_dvs,
   input  ate_pkg::div_side_type      in_side,
   output logic                       out_vld,
   output logic [ate_pkg::DIV_BITS-1:0] out_quo,
   output ate_pkg::div_side_type      out_side
);
   import ate_pkg::*;

   localparam int STAGES = DIV_BITS / STEPS;

   logic                vld_ff  [STAGES];
   logic [DIVR_W-1:0]   rem_ff  [STAGES];
   logic [DIV_BITS-1:0] nq_ff   [STAGES];
   logic [DIVR_W-1:0]   dvs_ff  [STAGES];
   div_side_type        side_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic                vld_src;
      logic [DIVR_W-1:0]   rem_src;
      logic [DIV_BITS-1:0] nq_src;
      logic [DIVR_W-1:0]   dvs_src;
      div_side_type        side_src;
      logic [DIVR_W-1:0]   rem_in;
      logic [DIV_BITS-1:0] nq_in;

      if (g == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rem_src  = '0;
         assign nq_src   = in_num;
         assign dvs_src  = in_dvs;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign nq_src   = nq_ff[g-1];
         assign dvs_src  = dvs_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      // dividend bits shift out the top while quotient bits shift in
      always_comb begin
         logic [DIVR_W:0] trial;
         rem_in = rem_src;
         nq_in  = nq_src;
         for (int s = 0; s < STEPS; s++) begin
            trial = {rem_in, nq_in[DIV_BITS-1]};
            nq_in = {nq_in[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_src}) begin
               trial    = trial - {1'b0, dvs_src};
               nq_in[0] = 1'b1;
            end
            rem_in = trial[DIVR_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            nq_ff[g]   <= nq_in;
            dvs_ff[g]  <= dvs_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = nq_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

/* src/ate_checker.sv */
// ----------------------------------------------------------------------------
// ate_checker
// Port-level checks for the exponential target calculator.
// ----------------------------------------------------------------------------
module ate_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ate_pkg::rsp_type rsp_data
);
   import ate_pkg::*;

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the pipe takes a word exactly when the response side can move
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   // a waiting request keeps valid until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request valid dropped before accept");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind asert_target_exponential ate_checker u_ate_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exponential target calculator. Requests go in
// through valid/ready with random gaps and response stalls. Every accepted
// request is run through a bit-exact predictor of the exponent, cubic factor,
// wide product, shift and clamping. Each response is compared field by field
// with the oldest prediction. Half-life and limit are swept over several
// settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ate_pkg::*;

   class target_scoreboard;
      rsp_type     pending_targets[$];
      logic [31:0] half_life;
      logic [255:0] limit;
      int          mismatches;
      int          matched;
      int          flagged;

      function new();
         half_life  = HALF_LIFE_RST;
         limit      = {LIMIT_HI_RST, LIMIT_LO_RST, LIMIT_LO_RST, LIMIT_LO_RST};
         mismatches = 0;
         matched    = 0;
         flagged    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
         case (idx)
            CSR_HALF_LIFE: half_life = val[31:0];
            CSR_LIMIT0:    limit[63:0] = val;
            CSR_LIMIT1:    limit[127:64] = val;
            CSR_LIMIT2:    limit[191:128] = val;
            CSR_LIMIT3:    limit[255:192] = val;
            default: ;
         endcase
      endfunction

      function rsp_type next_target(req_type it);
         rsp_type      r;
         logic [255:0] refv, res;
         logic [287:0] prod, sh;
         logic [575:0] wide;
         logic [63:0]  mag, hl, q, fr, poly;
         logic [16:0]  factor;
         longint       tv, dev, shifts;
         logic         err, neg, ovf;
         refv = {it.ref_word3, it.ref_word2, it.ref_word1, it.ref_word0};
         err  = (refv == 0) || (refv > limit);
         tv   = it.time_delta;
         dev  = tv - longint'(it.spacing) * longint'(it.height_delta);
         neg  = dev < 0;
         mag  = neg ? -dev : dev;
         // deviation saturates one short of 2^47
         if (mag >= 64'h8000_0000_0000) begin
            err = 1;
            mag = 64'h7FFF_FFFF_FFFF;
         end
         hl = half_life;
         if (hl == 0) begin
            err = 1;
            hl  = 1;
         end
         q = (mag << 16) / hl;
         if (!neg) begin
            shifts = longint'(q >> 16);
            fr     = q & 64'hFFFF;
         end else begin
            shifts = -longint'((q + 64'd65535) >> 16);
            fr     = (64'd0 - q) & 64'hFFFF;
         end
         poly = 64'd195766423245049 * fr + 64'd971821376 * fr * fr
              + 64'd5127 * fr * fr * fr + 64'h0000_8000_0000_0000;
         factor = 17'd65536 + 17'(poly >> 48);
         prod   = {32'd0, refv} * {271'd0, factor};
         shifts = shifts - 16;
         ovf    = 0;
         if (shifts <= 0) begin
            sh = (-shifts >= 288) ? '0 : prod >> (-shifts);
         end else if (shifts >= 288) begin
            sh  = '0;
            ovf = prod != 0;
         end else begin
            wide = {288'd0, prod} << shifts;
            ovf  = wide[575:288] != 0;
            sh   = wide[287:0];
         end
         res = (ovf || sh[287:256] != 0) ? limit : sh[255:0];
         if (res == 0) res = 256'd1;
         else if (res > limit) res = limit;
         r.next_word0  = res[63:0];
         r.next_word1  = res[127:64];
         r.next_word2  = res[191:128];
         r.next_word3  = res[255:192];
         r.input_error = err;
         return r;
      endfunction

      function void note(req_type it);
         pending_targets.push_back(next_target(it));
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (pending_targets.size() == 0) begin
            report("unexpected word", 64'd0, 64'd0);
            return;
         end
         want = pending_targets.pop_front();
         matched++;
         if (want.input_error) flagged++;
         if (got.next_word0 != want.next_word0) report("next_word0", got.next_word0, want.next_word0);
         if (got.next_word1 != want.next_word1) report("next_word1", got.next_word1, want.next_word1);
         if (got.next_word2 != want.next_word2) report("next_word2", got.next_word2, want.next_word2);
         if (got.next_word3 != want.next_word3) report("next_word3", got.next_word3, want.next_word3);
         if (got.input_error != want.input_error)
            report("input_error", 64'(got.input_error), 64'(want.input_error));
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   target_scoreboard sb = new();
   bit calm = 0;
   int sent = 0;

   asert_target_exponential u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note(req_data);
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
      end
   end

   function automatic logic [255:0] rand_target();
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
      case ($urandom_range(3))
         0: v = v >> $urandom_range(255);
         1: v = v >> $urandom_range(40);
         default: v = v >> (32 + $urandom_range(40));
      endcase
      return v;
   endfunction

   function automatic req_type make_req(logic [255:0] refv, logic [15:0] sp,
                                        logic [47:0] td, logic [31:0] hd);
      req_type r;
      {r.ref_word3, r.ref_word2, r.ref_word1, r.ref_word0} = refv;
      r.spacing      = sp;
      r.time_delta   = td;
      r.height_delta = hd;
      return r;
   endfunction

   task automatic send(req_type it);
      req_valid <= 1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // write enable stays high across a burst; the caller drops it at the end
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // hold off until every word is back, then let the pipe drain
   task automatic drain();
      req_valid <= 0;
      while (sb.pending_targets.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] hl, logic [255:0] lim);
      write_reg(CSR_HALF_LIFE, {32'd0, hl});
      write_reg(CSR_LIMIT0, lim[63:0]);
      write_reg(CSR_LIMIT1, lim[127:64]);
      write_reg(CSR_LIMIT2, lim[191:128]);
      write_reg(CSR_LIMIT3, lim[255:192]);
      csr_wr_en <= 0;
   endtask

   task automatic random_items(int n);
      logic [15:0] sp;
      logic [31:0] hd;
      logic [47:0] td;
      longint      off;
      for (int i = 0; i < n; i++) begin
         sp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 900));
         hd = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
         if ($urandom_range(4) == 0) begin
            td = {16'($urandom), 32'($urandom)};
         end else begin
            // near schedule, deviation spread over many scales
            off = longint'({$urandom, $urandom}) >>> $urandom_range(17, 63);
            td  = 48'(longint'(sp) * longint'(hd) + off);
         end
         send(make_req(rand_target(), sp, td, hd));
      end
   endtask

   initial begin
      logic [255:0] dflt, ones;
      dflt = {LIMIT_HI_RST, LIMIT_LO_RST, LIMIT_LO_RST, LIMIT_LO_RST};
      ones = '1;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners at the reset settings
      send(make_req(256'd0, 16'd600, 48'd0, 32'd0));
      send(make_req(256'd1, 16'd600, 48'd600, 32'd1));
      send(make_req(dflt, 16'd600, 48'd600, 32'd1));
      send(make_req(ones, 16'd600, 48'd600, 32'd1));
      send(make_req(dflt + 1, 16'd1, 48'd0, 32'd0));
      send(make_req(256'h1234_5678, 16'd1, 48'h7FFF_FFFF_FFFF, 32'd0));
      send(make_req(256'h1234_5678, 16'd1, 48'h8000_0000_0000, 32'd0));
      send(make_req(256'h1234_5678, 16'hFFFF, 48'd0, 32'hFFFF_FFFF));
      send(make_req(256'h1234_5678, 16'hFFFF, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send(make_req(dflt >> 8, 16'd600, 48'd172800, 32'd0));
      send(make_req(dflt >> 8, 16'd600, -48'sd172800, 32'd0));
      send(make_req(dflt >> 8, 16'd600, 48'd600 + 48'd3, 32'd1));
      send(make_req(dflt >> 8, 16'd600, 48'd600 - 48'd3, 32'd1));
      send(make_req(dflt >> 40, 16'd600, 48'd172800 * 48'd40, 32'd0));
      send(make_req(256'd5, 16'd600, -48'sd172800 * 48'sd20, 32'd0));
      send(make_req(dflt, 16'd600, 48'd172800 * 48'd3, 32'd0));
      random_items(150);
      drain();

      configure(32'd1, ones);
      send(make_req(ones, 16'd1, 48'd300, 32'd0));
      send(make_req(256'd1, 16'd1, -48'sd300, 32'd0));
      random_items(200);
      drain();

      configure(32'hFFFF_FFFF, rand_target());
      random_items(200);
      drain();

      // zero half-life and zero limit
      configure(32'd0, 256'd0);
      send(make_req(256'd0, 16'd1, 48'd0, 32'd0));
      random_items(100);
      drain();

      calm = 1;
      configure(32'd600, dflt);
      random_items(300);
      drain();
      calm = 0;

      for (int p = 0; p < 3; p++) begin
         configure($urandom_range(1, 2000000), rand_target() | (ones >> 64));
         random_items(100);
         drain();
      end

      $display("covered %0d requests over 8 register settings, %0d with input error",
               sent, sb.flagged);
      $display("%0d responses checked, %0d mismatches", sb.matched, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_targets.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("Test completed with failures");
      $finish;
   end

endmodule
